FILE: sv/slr_pkg.sv
// ---------------------------------------------------------------------------
// Quaternion slerp package
// Shared constants, CORDIC angle table and word types of the slerp pipeline.
// ---------------------------------------------------------------------------
package slr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int T_W       = 15;
  localparam int DOT_ONE   = 2 * FRAC_BITS;
  localparam int C_SHL     = 30 - 2 * FRAC_BITS;
  localparam int W_SHL     = 30 - FRAC_BITS;
  localparam int CORDIC_N  = 30;
  localparam int ROOT_W    = 31;
  localparam int DIV_NW    = 47;
  localparam int QUO_W     = 15;

  localparam logic [T_W-1:0] T_ONE      = T_W'(1 << FRAC_BITS);
  localparam logic [T_W-1:0] THR_RESET  = 15'd15892;
  localparam logic [33:0]    ROT_X0     = 34'd652032874;

  localparam logic [29:0] CORDIC_ANGLE [CORDIC_N] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2
  };

  typedef struct packed {
    logic signed [15:0] from_x;
    logic signed [15:0] from_y;
    logic signed [15:0] from_z;
    logic signed [15:0] from_w;
    logic signed [15:0] to_x;
    logic signed [15:0] to_y;
    logic signed [15:0] to_z;
    logic signed [15:0] to_w;
    logic [14:0]        blend;
  } slr_in_t;

  typedef struct packed {
    logic signed [15:0] res_x;
    logic signed [15:0] res_y;
    logic signed [15:0] res_z;
    logic signed [15:0] res_w;
    logic               used_linear;
    logic               degenerate;
  } slr_out_t;

  // Operands that ride along the angle part of the pipeline.
  typedef struct packed {
    logic [3:0][16:0] f;
    logic [3:0][15:0] g;
    logic [T_W-1:0]   t;
    logic             lin;
  } slr_side_t;

  // Operands that ride along the length square root.
  typedef struct packed {
    logic [3:0][ROOT_W-1:0] mag;
    logic [3:0]             sgn;
    logic                   lin;
    logic                   zero;
  } slr_nrm_t;

  typedef struct packed {
    logic [3:0] sgn;
    logic       lin;
    logic       zero;
  } slr_fin_t;

endpackage

FILE: sv/quaternion_slerp.sv
// ---------------------------------------------------------------------------
// Quaternion slerp
// Normalized spherical interpolation of two Q2.14 quaternions.
// ---------------------------------------------------------------------------
// The input channel (in_valid_i / in_ready_o / in_data_i) takes one word with
// the start and end quaternions and the blend fraction. The output channel
// (out_valid_o / out_ready_i / out_data_o) returns one word with the unit
// result and the used_linear and degenerate flags for every input word.
// The pipeline takes a new word in every cycle while the output flows. Each
// word passes the two 31-stage square roots, the 30-stage vectoring and
// rotation CORDIC chains and the 15-stage divider, plus twelve single stages
// for the products, sums, angle split, weights and the output register.
// The whole pipeline advances as one: when the output register holds a word
// that the receiver does not take, every stage holds and in_ready_o drops, so
// nothing is lost or repeated. cfg_we_i loads the linear threshold (Q1.14).
// Reset clears all valid bits and sets the threshold to 0.97.
// ---------------------------------------------------------------------------
module quaternion_slerp import slr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  slr_in_t        in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output slr_out_t       out_data_o,
  input  logic           cfg_we_i,
  input  logic [T_W-1:0] cfg_data_i
);

  localparam int SIDE_W = $bits(slr_side_t);

  logic           en;
  logic [T_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: component products.
  logic signed [15:0] in_f [4];
  logic signed [15:0] in_g [4];
  logic               s1_vld_q;
  logic signed [31:0] s1_prod_q [4];
  logic [3:0][15:0]   s1_f_q, s1_g_q;
  logic [T_W-1:0]     s1_t_q;

  assign in_f[0] = in_data_i.from_x;
  assign in_f[1] = in_data_i.from_y;
  assign in_f[2] = in_data_i.from_z;
  assign in_f[3] = in_data_i.from_w;
  assign in_g[0] = in_data_i.to_x;
  assign in_g[1] = in_data_i.to_y;
  assign in_g[2] = in_data_i.to_z;
  assign in_g[3] = in_data_i.to_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_prod_q[i] <= in_f[i] * in_g[i];
        s1_f_q[i]    <= in_f[i];
        s1_g_q[i]    <= in_g[i];
      end
      s1_t_q <= (in_data_i.blend > T_ONE) ? T_ONE : in_data_i.blend;
    end
  end

  // Stage 2: dot product.
  logic               s2_vld_q;
  logic signed [33:0] s2_dot_q;
  logic [3:0][15:0]   s2_f_q, s2_g_q;
  logic [T_W-1:0]     s2_t_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_dot_q <= 34'(s1_prod_q[0]) + 34'(s1_prod_q[1])
                + 34'(s1_prod_q[2]) + 34'(s1_prod_q[3]);
      s2_f_q   <= s1_f_q;
      s2_g_q   <= s1_g_q;
      s2_t_q   <= s1_t_q;
    end
  end

  // Stage 3: fold to the short arc, pick the weight kind, form the cosine.
  logic [33:0]     s3_abs;
  logic [32:0]     s3_ud;
  logic            s3_neg;
  slr_side_t       s3_side_d, s3_side_q;
  logic            s3_vld_q;
  logic [29:0]     s3_c_q;
  logic [16:0]     s3_fx;

  always_comb begin
    s3_neg = s2_dot_q[33];
    s3_abs = s3_neg ? 34'(-s2_dot_q) : 34'(s2_dot_q);
    s3_ud  = s3_abs[32:0];
    s3_fx  = '0;
    for (int i = 0; i < 4; i++) begin
      s3_fx            = {s2_f_q[i][15], s2_f_q[i]};
      s3_side_d.f[i]   = s3_neg ? 17'(-s3_fx) : s3_fx;
      s3_side_d.g[i]   = s2_g_q[i];
    end
    s3_side_d.t   = s2_t_q;
    s3_side_d.lin = (s3_ud > (33'(thr_q) << FRAC_BITS)) || ((s3_ud >> DOT_ONE) != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q <= s3_side_d;
      s3_c_q    <= 30'(s3_ud << C_SHL);
    end
  end

  // Stage 4: cosine squared.
  logic            s4_vld_q;
  logic [59:0]     s4_csq_q;
  logic [29:0]     s4_c_q;
  slr_side_t       s4_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_csq_q  <= s3_c_q * s3_c_q;
      s4_c_q    <= s3_c_q;
      s4_side_q <= s3_side_q;
    end
  end

  // Sine from the cosine, then the angle.
  logic                  sq1_vld;
  logic [ROOT_W-1:0]     sq1_s;
  logic [SIDE_W+29:0]    sq1_side;
  logic [2*ROOT_W-1:0]   sq1_rad;

  assign sq1_rad = (62'd1 << 60) - 62'(s4_csq_q);

  slr_isqrt #(.OUT_W(ROOT_W), .SIDE_W(SIDE_W + 30)) u_sqrt_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s4_vld_q),
    .rad_i  (sq1_rad),
    .side_i ({s4_c_q, s4_side_q}),
    .vld_o  (sq1_vld),
    .root_o (sq1_s),
    .side_o (sq1_side)
  );

  logic               vec_vld;
  logic signed [32:0] vec_th;
  slr_side_t          vec_side;

  slr_cordic_vec #(.SIDE_W(SIDE_W)) u_vec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq1_vld),
    .x_i    (sq1_side[SIDE_W +: 30]),
    .y_i    (sq1_s),
    .side_i (sq1_side[SIDE_W-1:0]),
    .vld_o  (vec_vld),
    .th_o   (vec_th),
    .side_o (vec_side)
  );

  // Stage 5: split the angle by the blend fraction.
  logic          s5_vld_q;
  logic [30:0]   s5_th_q, s5_pb_q;
  slr_side_t     s5_side_q;
  logic [30:0]   s5_th;
  logic [45:0]   s5_prod;

  always_comb begin
    s5_th   = vec_th[32] ? '0 : vec_th[30:0];
    s5_prod = s5_th * vec_side.t;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_th_q   <= s5_th;
      s5_pb_q   <= 31'(s5_prod >> FRAC_BITS);
      s5_side_q <= vec_side;
    end
  end

  // Stage 6: remaining angle.
  logic          s6_vld_q;
  logic [30:0]   s6_pa_q, s6_pb_q;
  slr_side_t     s6_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_pa_q   <= s5_th_q - s5_pb_q;
      s6_pb_q   <= s5_pb_q;
      s6_side_q <= s5_side_q;
    end
  end

  logic          rot_vld;
  logic [31:0]   rot_sa, rot_sb;
  slr_side_t     rot_side;

  slr_cordic_rot #(.SIDE_W(SIDE_W)) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s6_vld_q),
    .za_i   (s6_pa_q),
    .zb_i   (s6_pb_q),
    .side_i (s6_side_q),
    .vld_o  (rot_vld),
    .sa_o   (rot_sa),
    .sb_o   (rot_sb),
    .side_o (rot_side)
  );

  // Stage 7: final weights. Both sines at zero falls back to linear weights.
  logic          s7_vld_q;
  logic [31:0]   s7_wa_q, s7_wb_q;
  slr_side_t     s7_side_d, s7_side_q;
  logic          s7_lin;

  assign s7_lin = rot_side.lin || (rot_sa == '0 && rot_sb == '0);

  always_comb begin
    s7_side_d     = rot_side;
    s7_side_d.lin = s7_lin;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_side_q <= s7_side_d;
      if (s7_lin) begin
        s7_wa_q <= 32'(T_ONE - rot_side.t) << W_SHL;
        s7_wb_q <= 32'(rot_side.t) << W_SHL;
      end else begin
        s7_wa_q <= rot_sa;
        s7_wb_q <= rot_sb;
      end
    end
  end

  // Stage 8: weighted components.
  logic               s8_vld_q;
  logic signed [49:0] s8_pa_q [4];
  logic signed [49:0] s8_pb_q [4];
  logic               s8_lin_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s8_pa_q[i] <= $signed(s7_side_q.f[i]) * $signed({1'b0, s7_wa_q});
        s8_pb_q[i] <= $signed(s7_side_q.g[i]) * $signed({1'b0, s7_wb_q});
      end
      s8_lin_q <= s7_side_q.lin;
    end
  end

  // Stage 9: blended components.
  logic               s9_vld_q;
  logic signed [31:0] s9_v_q [4];
  logic signed [50:0] s9_sum [4];
  logic               s9_lin_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s9_sum[i] = 51'(s8_pa_q[i]) + 51'(s8_pb_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s9_v_q[i] <= 32'(s9_sum[i] >>> 16);
      end
      s9_lin_q <= s8_lin_q;
    end
  end

  // Stage 10: magnitudes and squares.
  logic                    s10_vld_q;
  logic [61:0]             s10_sq_q [4];
  logic [3:0][ROOT_W-1:0]  s10_mag_q;
  logic [3:0]              s10_sgn_q;
  logic                    s10_lin_q;
  logic [31:0]             s10_abs [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s10_abs[i] = s9_v_q[i][31] ? 32'(-s9_v_q[i]) : 32'(s9_v_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s10_sq_q[i]  <= s10_abs[i][30:0] * s10_abs[i][30:0];
        s10_mag_q[i] <= s10_abs[i][30:0];
        s10_sgn_q[i] <= s9_v_q[i][31];
      end
      s10_lin_q <= s9_lin_q;
    end
  end

  // Stage 11: squared length.
  logic            s11_vld_q;
  logic [63:0]     s11_len2;
  logic [61:0]     s11_len2_q;
  slr_nrm_t        s11_nrm_q;

  assign s11_len2 = 64'(s10_sq_q[0]) + 64'(s10_sq_q[1])
                  + 64'(s10_sq_q[2]) + 64'(s10_sq_q[3]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s11_len2_q     <= s11_len2[61:0];
      s11_nrm_q.mag  <= s10_mag_q;
      s11_nrm_q.sgn  <= s10_sgn_q;
      s11_nrm_q.lin  <= s10_lin_q;
      s11_nrm_q.zero <= (s11_len2 == '0);
    end
  end

  logic              sq2_vld;
  logic [ROOT_W-1:0] sq2_len;
  slr_nrm_t          sq2_nrm;

  slr_isqrt #(.OUT_W(ROOT_W), .SIDE_W($bits(slr_nrm_t))) u_sqrt_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s11_vld_q),
    .rad_i  (s11_len2_q),
    .side_i (s11_nrm_q),
    .vld_o  (sq2_vld),
    .root_o (sq2_len),
    .side_o (sq2_nrm)
  );

  // Rounded quotient: (2 * mag * one + len) / (2 * len).
  logic [3:0][DIV_NW-1:0] div_num;
  logic [31:0]            div_den;
  slr_fin_t               div_side_in, div_side;
  logic                   div_vld;
  logic [3:0][QUO_W-1:0]  div_quo;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      div_num[i] = (DIV_NW'(sq2_nrm.mag[i]) << (FRAC_BITS + 1)) + DIV_NW'(sq2_len);
    end
    div_den          = {sq2_len, 1'b0};
    div_side_in.sgn  = sq2_nrm.sgn;
    div_side_in.lin  = sq2_nrm.lin;
    div_side_in.zero = sq2_nrm.zero;
  end

  slr_div #(.SIDE_W($bits(slr_fin_t))) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sq2_vld),
    .num_i  (div_num),
    .den_i  (div_den),
    .side_i (div_side_in),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  // Output register.
  logic [15:0] res [4];
  slr_out_t    out_d, out_q;
  logic        out_vld_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (div_side.zero) begin
        res[i] = '0;
      end else if (div_side.sgn[i]) begin
        res[i] = 16'(-{1'b0, div_quo[i]});
      end else begin
        res[i] = {1'b0, div_quo[i]};
      end
    end
    out_d.res_x       = res[0];
    out_d.res_y       = res[1];
    out_d.res_z       = res[2];
    out_d.res_w       = res[3];
    out_d.used_linear = div_side.lin;
    out_d.degenerate  = div_side.zero;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // Valid bits of the stages in this file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= vec_vld;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= rot_vld;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= s10_vld_q;
      out_vld_q <= div_vld;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/slr_isqrt.sv
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit restoring square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module slr_isqrt import slr_pkg::*; #(
  parameter int OUT_W  = 31,
  parameter int SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [2*OUT_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 vld_o,
  output logic [OUT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int RW = OUT_W + 3;

  logic [RW-1:0]        rem_q  [OUT_W];
  logic [RW-1:0]        rem_d  [OUT_W];
  logic [OUT_W-1:0]     root_q [OUT_W];
  logic [OUT_W-1:0]     root_d [OUT_W];
  logic [2*OUT_W-1:0]   rad_q  [OUT_W];
  logic [2*OUT_W-1:0]   rad_d  [OUT_W];
  logic [SIDE_W-1:0]    side_q [OUT_W];
  logic [OUT_W-1:0]     vld_q;

  logic [RW-1:0]        rem_s, remx, trial;
  logic [OUT_W-1:0]     root_s;
  logic [2*OUT_W-1:0]   rad_s;

  always_comb begin
    rem_s  = '0;
    remx   = '0;
    trial  = '0;
    root_s = '0;
    rad_s  = '0;
    for (int k = 0; k < OUT_W; k++) begin
      if (k == 0) begin
        rem_s  = '0;
        root_s = '0;
        rad_s  = rad_i;
      end else begin
        rem_s  = rem_q[k-1];
        root_s = root_q[k-1];
        rad_s  = rad_q[k-1];
      end
      remx  = {rem_s[RW-3:0], rad_s[2*OUT_W-1 -: 2]};
      trial = RW'({root_s, 2'b01});
      if (remx >= trial) begin
        rem_d[k]  = remx - trial;
        root_d[k] = {root_s[OUT_W-2:0], 1'b1};
      end else begin
        rem_d[k]  = remx;
        root_d[k] = {root_s[OUT_W-2:0], 1'b0};
      end
      rad_d[k] = {rad_s[2*OUT_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[OUT_W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < OUT_W; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        rad_q[k]  <= rad_d[k];
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[OUT_W-1];
  assign root_o = root_q[OUT_W-1];
  assign side_o = side_q[OUT_W-1];

endmodule

FILE: sv/slr_cordic_vec.sv
// ---------------------------------------------------------------------------
// CORDIC vectoring pipeline
// Forms the angle of (x, y) in Q30 radians, one micro-rotation per stage.
// ---------------------------------------------------------------------------
module slr_cordic_vec import slr_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [29:0]        x_i,
  input  logic [30:0]        y_i,
  input  logic [SIDE_W-1:0]  side_i,
  output logic               vld_o,
  output logic signed [32:0] th_o,
  output logic [SIDE_W-1:0]  side_o
);

  localparam int XW = 34;
  localparam int ZW = 33;

  logic signed [XW-1:0] x_q [CORDIC_N];
  logic signed [XW-1:0] x_d [CORDIC_N];
  logic signed [XW-1:0] y_q [CORDIC_N];
  logic signed [XW-1:0] y_d [CORDIC_N];
  logic signed [ZW-1:0] z_q [CORDIC_N];
  logic signed [ZW-1:0] z_d [CORDIC_N];
  logic [SIDE_W-1:0]    side_q [CORDIC_N];
  logic [CORDIC_N-1:0]  vld_q;

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] zs, ang;

  always_comb begin
    xs  = '0;
    ys  = '0;
    zs  = '0;
    ang = '0;
    for (int k = 0; k < CORDIC_N; k++) begin
      if (k == 0) begin
        xs = $signed({4'b0, x_i});
        ys = $signed({3'b0, y_i});
        zs = '0;
      end else begin
        xs = x_q[k-1];
        ys = y_q[k-1];
        zs = z_q[k-1];
      end
      ang = $signed({3'b0, CORDIC_ANGLE[k]});
      // Rotate toward the x axis and add up the angle turned.
      if (!ys[XW-1]) begin
        x_d[k] = xs + (ys >>> k);
        y_d[k] = ys - (xs >>> k);
        z_d[k] = zs + ang;
      end else begin
        x_d[k] = xs - (ys >>> k);
        y_d[k] = ys + (xs >>> k);
        z_d[k] = zs - ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CORDIC_N-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CORDIC_N; k++) begin
        x_q[k]    <= x_d[k];
        y_q[k]    <= y_d[k];
        z_q[k]    <= z_d[k];
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[CORDIC_N-1];
  assign th_o   = z_q[CORDIC_N-1];
  assign side_o = side_q[CORDIC_N-1];

endmodule

FILE: sv/slr_cordic_rot.sv
// ---------------------------------------------------------------------------
// CORDIC rotation pipeline, two lanes
// Computes the sines of two angles, clamped at zero, in Q30.
// ---------------------------------------------------------------------------
module slr_cordic_rot import slr_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [30:0]       za_i,
  input  logic [30:0]       zb_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [31:0]       sa_o,
  output logic [31:0]       sb_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int XW = 34;
  localparam int ZW = 33;

  logic signed [XW-1:0] x_q [2][CORDIC_N];
  logic signed [XW-1:0] x_d [2][CORDIC_N];
  logic signed [XW-1:0] y_q [2][CORDIC_N];
  logic signed [XW-1:0] y_d [2][CORDIC_N];
  logic signed [ZW-1:0] z_q [2][CORDIC_N];
  logic signed [ZW-1:0] z_d [2][CORDIC_N];
  logic [SIDE_W-1:0]    side_q [CORDIC_N];
  logic [CORDIC_N-1:0]  vld_q;

  logic signed [XW-1:0] xs, ys;
  logic signed [ZW-1:0] zs, ang;
  logic signed [XW-1:0] ya, yb;

  always_comb begin
    xs  = '0;
    ys  = '0;
    zs  = '0;
    ang = '0;
    for (int l = 0; l < 2; l++) begin
      for (int k = 0; k < CORDIC_N; k++) begin
        if (k == 0) begin
          xs = $signed(ROT_X0);
          ys = '0;
          zs = $signed({2'b0, (l == 0) ? za_i : zb_i});
        end else begin
          xs = x_q[l][k-1];
          ys = y_q[l][k-1];
          zs = z_q[l][k-1];
        end
        ang = $signed({3'b0, CORDIC_ANGLE[k]});
        if (!zs[ZW-1]) begin
          x_d[l][k] = xs - (ys >>> k);
          y_d[l][k] = ys + (xs >>> k);
          z_d[l][k] = zs - ang;
        end else begin
          x_d[l][k] = xs + (ys >>> k);
          y_d[l][k] = ys - (xs >>> k);
          z_d[l][k] = zs + ang;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CORDIC_N-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < CORDIC_N; k++) begin
        for (int l = 0; l < 2; l++) begin
          x_q[l][k] <= x_d[l][k];
          y_q[l][k] <= y_d[l][k];
          z_q[l][k] <= z_d[l][k];
        end
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  assign ya     = y_q[0][CORDIC_N-1];
  assign yb     = y_q[1][CORDIC_N-1];
  assign sa_o   = ya[XW-1] ? '0 : ya[31:0];
  assign sb_o   = yb[XW-1] ? '0 : yb[31:0];
  assign vld_o  = vld_q[CORDIC_N-1];
  assign side_o = side_q[CORDIC_N-1];

endmodule

FILE: sv/slr_div.sv
// ---------------------------------------------------------------------------
// Pipelined restoring divider, four lanes
// Divides four numerators by one shared divisor, one quotient bit per stage.
// ---------------------------------------------------------------------------
module slr_div import slr_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [3:0][DIV_NW-1:0]      num_i,
  input  logic [31:0]                 den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        vld_o,
  output logic [3:0][QUO_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  logic [DIV_NW-1:0] rem_q [4][QUO_W];
  logic [DIV_NW-1:0] rem_d [4][QUO_W];
  logic [QUO_W-1:0]  quo_q [4][QUO_W];
  logic [QUO_W-1:0]  quo_d [4][QUO_W];
  logic [31:0]       den_q [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [QUO_W-1:0]  vld_q;

  logic [DIV_NW-1:0] rem_s, dsh;
  logic [QUO_W-1:0]  quo_s;
  logic [31:0]       den_s;

  always_comb begin
    rem_s = '0;
    quo_s = '0;
    den_s = '0;
    dsh   = '0;
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < QUO_W; k++) begin
        if (k == 0) begin
          rem_s = num_i[l];
          quo_s = '0;
          den_s = den_i;
        end else begin
          rem_s = rem_q[l][k-1];
          quo_s = quo_q[l][k-1];
          den_s = den_q[k-1];
        end
        // Stage k settles quotient bit QUO_W-1-k.
        dsh = DIV_NW'(den_s) << (QUO_W - 1 - k);
        if (rem_s >= dsh) begin
          rem_d[l][k] = rem_s - dsh;
          quo_d[l][k] = {quo_s[QUO_W-2:0], 1'b1};
        end else begin
          rem_d[l][k] = rem_s;
          quo_d[l][k] = {quo_s[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QUO_W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < QUO_W; k++) begin
        for (int l = 0; l < 4; l++) begin
          rem_q[l][k] <= rem_d[l][k];
          quo_q[l][k] <= quo_d[l][k];
        end
        den_q[k]  <= (k == 0) ? den_i : den_q[k-1];
        side_q[k] <= (k == 0) ? side_i : side_q[k-1];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      quo_o[l] = quo_q[l][QUO_W-1];
    end
  end

  assign vld_o  = vld_q[QUO_W-1];
  assign side_o = side_q[QUO_W-1];

endmodule

FILE: sv/slr_checker.sv
// ---------------------------------------------------------------------------
// Quaternion slerp port checker
// Watches the ports of the slerp block for flow-control and result slips.
// ---------------------------------------------------------------------------
module slr_checker import slr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input slr_out_t out_data_o
);

  // A word that waits at the output keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // The input side is open exactly when the output register can move.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow the output stall");

  // A degenerate word carries an all-zero quaternion.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.res_x == '0 && out_data_o.res_y == '0 &&
      out_data_o.res_z == '0 && out_data_o.res_w == '0)
    else $error("degenerate word with nonzero components");

  // A normalized quaternion always has a nonzero component.
  a_norm_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.degenerate |->
      out_data_o.res_x != '0 || out_data_o.res_y != '0 ||
      out_data_o.res_z != '0 || out_data_o.res_w != '0)
    else $error("normalized word is all zero");

endmodule

bind quaternion_slerp slr_checker u_slr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
